### rtl/core/fsdr_pkg.sv
// Shared constants, angle table and helper function for the fault strike, dip and rake core.
package fsdr_pkg;

	localparam int NORMAL_WIDTH = 16;
	localparam int SLIP_WIDTH   = 32;
	localparam int NSH          = (NORMAL_WIDTH > 16) ? NORMAL_WIDTH - 16 : 0;
	localparam int SSH          = (SLIP_WIDTH > 32) ? SLIP_WIDTH - 32 : 0;

	localparam int CORDIC_STEPS = 20;
	localparam int SQ_STEPS     = 31;
	localparam int ANG_LAT      = CORDIC_STEPS + 3;

	localparam logic [13:0] DEG90  = 14'd5760;
	localparam logic [13:0] DEG180 = 14'd11520;
	localparam int          Z180   = 180 * 65536;

	// Arctangent of 2^-i in degrees, Q16.
	localparam logic [21:0] ATAN_TAB [CORDIC_STEPS] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
		22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
		22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
		22'd115,     22'd57,      22'd29,     22'd14,     22'd7
	};

	function automatic logic [5:0] msb48(input logic [47:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

### rtl/core/fsdr_angle.sv
// Pipelined CORDIC arctangent unit giving atan2(y, x) in 1/64 degree.
module fsdr_angle import fsdr_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic        [30:0] y,
	input  logic signed [31:0] x,
	output logic        [13:0] ang
);

	typedef struct packed {
		logic        xneg;
		logic        spec;
		logic [13:0] fix;
	} ang_ctl_t;

	logic        [31:0] ux_w;
	ang_ctl_t           ctl_w;
	logic        [5:0]  p_w;

	logic        [30:0] y_s1;
	logic        [31:0] ux_s1;
	logic        [5:0]  p_s1;
	ang_ctl_t           ctl_s1;

	logic signed [33:0] cx [CORDIC_STEPS+1];
	logic signed [33:0] cy [CORDIC_STEPS+1];
	logic signed [25:0] cz [CORDIC_STEPS+1];
	ang_ctl_t           cc [CORDIC_STEPS+1];

	logic        [63:0] xsh_w;
	logic        [63:0] ysh_w;
	logic signed [26:0] zf_w;
	logic        [24:0] zr_w;
	logic        [24:0] zrr_w;
	logic        [13:0] ang_s23;

	always_comb begin
		ux_w = x[31] ? 32'(-x) : 32'(x);
		p_w  = msb48(48'(y) | 48'(ux_w));
		ctl_w.xneg = x[31];
		ctl_w.spec = 1'b1;
		if (y == '0 && ux_w == '0) begin
			ctl_w.fix = '0;
		end else if (y == '0) begin
			ctl_w.fix = x[31] ? DEG180 : '0;
		end else if (ux_w == '0) begin
			ctl_w.fix = DEG90;
		end else begin
			ctl_w.spec = 1'b0;
			ctl_w.fix  = '0;
		end
	end

	always_comb begin
		xsh_w = (64'(ux_s1) << 29) >> p_s1;
		ysh_w = (64'(y_s1) << 29) >> p_s1;
	end

	always_comb begin
		zf_w = cc[CORDIC_STEPS].xneg ? 27'(Z180) - 27'(cz[CORDIC_STEPS])
		                             : 27'(cz[CORDIC_STEPS]);
		if (zf_w < 0) begin
			zr_w = '0;
		end else if (zf_w > 27'(Z180)) begin
			zr_w = 25'(Z180);
		end else begin
			zr_w = zf_w[24:0];
		end
		zrr_w = zr_w + 25'd512;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1   <= y;
			ux_s1  <= ux_w;
			p_s1   <= p_w;
			ctl_s1 <= ctl_w;

			cx[0] <= $signed({4'b0, xsh_w[29:0]});
			cy[0] <= $signed({4'b0, ysh_w[29:0]});
			cz[0] <= '0;
			cc[0] <= ctl_s1;

			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (cy[i] > 0) begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + $signed(26'(ATAN_TAB[i]));
				end else begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - $signed(26'(ATAN_TAB[i]));
				end
				cc[i+1] <= cc[i];
			end

			ang_s23 <= cc[CORDIC_STEPS].spec ? cc[CORDIC_STEPS].fix : zrr_w[23:10];
		end
	end

	assign ang = ang_s23;

endmodule

### rtl/core/fault_strike_dip_rake_core.sv
// Top level of the fault strike, dip and rake core with its pipeline and register port.
// The core takes one transaction per cycle while item_stall is low. It holds the 31-step
// integer square root and the 20-step CORDIC arctangent, each step being one pipeline
// stage. When a result waits with result_stall high, the whole pipeline holds and
// item_stall rises in the same cycle. The register
// rupture_threshold at address 0 should only be written while no transaction is in flight.
module fault_strike_dip_rake_core import fsdr_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic signed [NORMAL_WIDTH-1:0] normal_x,
	input  logic signed [NORMAL_WIDTH-1:0] normal_y,
	input  logic signed [NORMAL_WIDTH-1:0] normal_z,
	input  logic signed [SLIP_WIDTH-1:0]   slip_x,
	input  logic signed [SLIP_WIDTH-1:0]   slip_y,
	input  logic signed [SLIP_WIDTH-1:0]   slip_z,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [13:0]             strike_deg,
	output logic        [13:0]             dip_deg,
	output logic        [13:0]             rake_deg,
	output logic                           ruptured,
	output logic                           degenerate,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic        [2:0]              paddr,
	input  logic        [31:0]             pwdata,
	output logic        [31:0]             prdata,
	output logic                           pready
);

	localparam logic THR_IDX = 1'b0;

	typedef struct packed {
		logic fny_pos;
		logic degen;
		logic rup;
		logic rake_ok;
	} fin_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic        [15:0] nz_mag;
		logic        [15:0] ny_mag;
		logic        [29:0] cd;
		logic               dot_neg;
		fin_t               fin;
	} side_t;

	typedef struct packed {
		logic [61:0] rem;
		logic [61:0] root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t s, input int k);
		sq_t         o;
		logic [61:0] bit_v;
		logic [61:0] trial;
		bit_v = 62'(1) << (60 - 2 * k);
		trial = s.root + bit_v;
		if (s.rem >= trial) begin
			o.rem  = s.rem - trial;
			o.root = (s.root >> 1) + bit_v;
		end else begin
			o.rem  = s.rem;
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic logic [29:0] norm30(input logic [47:0] v, input logic [5:0] p);
		logic [77:0] w;
		w = (78'(v) << 29) >> p;
		return w[29:0];
	endfunction

	logic        en;
	logic [30:0] thr_q;

	// Front end.
	logic signed [31:0] nx32_w, ny32_w, nz32_w;
	logic signed [15:0] nx_w, ny_w, nz_w;
	logic signed [47:0] sx48_w, sy48_w, sz48_w;
	logic        [47:0] ax48_w, ay48_w, az48_w;
	side_t              side_w;

	logic               vld_s1;
	side_t              side_s1;
	logic signed [15:0] nx_s1, nz_s1;
	logic signed [31:0] sx_s1, sy_s1, sz_s1;
	logic        [30:0] ax_s1, ay_s1, az_s1;
	logic               big_s1;

	logic signed [31:0] nxx_w, nzz_w;
	logic               vld_s2;
	side_t              side_s2;
	logic               big_s2;
	logic        [61:0] sqx_s2, sqy_s2, sqz_s2, thr_sq_s2;
	logic        [30:0] nxx_s2, nzz_s2;
	logic signed [47:0] p_ynx_s2, p_xnx_s2, p_znz_s2, p_ynz_s2, p_xnz_s2, p_znx_s2;

	logic        [63:0] sum_sq_w;
	logic        [31:0] nsum_w;
	side_t              side3_w;
	logic               vld_s3;
	side_t              side_s3;
	logic signed [48:0] cb_s3, dot_s3;
	logic        [47:0] ca_s3, cc_s3;
	logic        [61:0] radt_s3;

	logic        [48:0] cbm_w, cdm_w;
	logic        [47:0] or_w;
	side_t              side4_w;
	logic               vld_s4;
	side_t              side_s4;
	logic        [47:0] ca_s4, cb_s4, cc_s4, cd_s4;
	logic        [5:0]  p_s4;
	logic        [61:0] radt_s4;

	side_t              side5_w;
	logic               vld_s5;
	side_t              side_s5;
	logic        [29:0] ca_s5, cb_s5, cc_s5;
	logic        [61:0] radt_s5;

	logic               vld_s6;
	side_t              side_s6;
	logic        [59:0] qa_s6, qb_s6, qc_s6;
	logic        [61:0] radt_s6;

	// Square root stages, index 0 holds the radicands.
	logic               vld_sq  [SQ_STEPS+1];
	side_t              side_sq [SQ_STEPS+1];
	sq_t                sqt     [SQ_STEPS+1];
	sq_t                sqr     [SQ_STEPS+1];

	// Angle stages.
	side_t              side_end;
	logic        [30:0] st_y_w, th_y_w;
	logic signed [31:0] st_x_w, th_x_w, rk_x_w;
	logic        [13:0] ang_st, ang_th, ang_rk;
	logic               vld_an [ANG_LAT];
	fin_t               fin_an [ANG_LAT];

	// Output stage.
	logic        [14:0] strike_w;
	logic        [13:0] theta_w;
	logic        [13:0] dip_w;
	fin_t               fin_end;
	logic               res_vld_s62;
	logic        [13:0] strike_s62, dip_s62, rake_s62;
	logic               rup_s62, degen_s62;

	assign en         = !(res_vld_s62 && result_stall);
	assign item_stall = !en;
	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == THR_IDX) ? {1'b0, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == THR_IDX) begin
			thr_q <= pwdata[30:0];
		end
	end

	always_comb begin
		nx32_w = 32'(normal_x);
		ny32_w = 32'(normal_y);
		nz32_w = 32'(normal_z);
		nx_w   = 16'(nx32_w >>> NSH);
		ny_w   = 16'(ny32_w >>> NSH);
		nz_w   = 16'(nz32_w >>> NSH);
		sx48_w = 48'(slip_x);
		sy48_w = 48'(slip_y);
		sz48_w = 48'(slip_z);
		ax48_w = sx48_w[47] ? 48'(-sx48_w) : 48'(sx48_w);
		ay48_w = sy48_w[47] ? 48'(-sy48_w) : 48'(sy48_w);
		az48_w = sz48_w[47] ? 48'(-sz48_w) : 48'(sz48_w);
		side_w             = '0;
		side_w.nx          = nx_w;
		side_w.nz_mag      = nz_w[15] ? 16'(-nz_w) : 16'(nz_w);
		side_w.ny_mag      = ny_w[15] ? 16'(-ny_w) : 16'(ny_w);
		side_w.fin.fny_pos = !normal_y[NORMAL_WIDTH-1] && (normal_y != '0);
		side_w.fin.degen   = (nx_w == '0) && (nz_w == '0);
	end

	always_comb begin
		nxx_w = nx_s1 * nx_s1;
		nzz_w = nz_s1 * nz_s1;
	end

	always_comb begin
		sum_sq_w = 64'(sqx_s2) + 64'(sqy_s2) + 64'(sqz_s2);
		nsum_w   = 32'(nxx_s2) + 32'(nzz_s2);
		side3_w         = side_s2;
		side3_w.fin.rup = big_s2 || (sum_sq_w > 64'(thr_sq_s2));
	end

	always_comb begin
		cbm_w = cb_s3[48] ? 49'(-cb_s3) : 49'(cb_s3);
		cdm_w = dot_s3[48] ? 49'(-dot_s3) : 49'(dot_s3);
		or_w  = ca_s3 | cbm_w[47:0] | cc_s3 | cdm_w[47:0];
		side4_w             = side_s3;
		side4_w.dot_neg     = dot_s3[48];
		side4_w.fin.rake_ok = (or_w != '0);
	end

	always_comb begin
		side5_w    = side_s4;
		side5_w.cd = norm30(cd_s4, p_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_w;
			nx_s1   <= nx_w;
			nz_s1   <= nz_w;
			sx_s1   <= 32'(sx48_w >>> SSH);
			sy_s1   <= 32'(sy48_w >>> SSH);
			sz_s1   <= 32'(sz48_w >>> SSH);
			ax_s1   <= ax48_w[30:0];
			ay_s1   <= ay48_w[30:0];
			az_s1   <= az48_w[30:0];
			big_s1  <= (|ax48_w[47:31]) || (|ay48_w[47:31]) || (|az48_w[47:31]);

			side_s2   <= side_s1;
			big_s2    <= big_s1;
			sqx_s2    <= ax_s1 * ax_s1;
			sqy_s2    <= ay_s1 * ay_s1;
			sqz_s2    <= az_s1 * az_s1;
			thr_sq_s2 <= thr_q * thr_q;
			nxx_s2    <= nxx_w[30:0];
			nzz_s2    <= nzz_w[30:0];
			p_ynx_s2  <= sy_s1 * nx_s1;
			p_xnx_s2  <= sx_s1 * nx_s1;
			p_znz_s2  <= sz_s1 * nz_s1;
			p_ynz_s2  <= sy_s1 * nz_s1;
			p_xnz_s2  <= sx_s1 * nz_s1;
			p_znx_s2  <= sz_s1 * nx_s1;

			side_s3 <= side3_w;
			cb_s3   <= 49'(p_xnx_s2) + 49'(p_znz_s2);
			dot_s3  <= 49'(p_xnz_s2) - 49'(p_znx_s2);
			ca_s3   <= p_ynx_s2[47] ? 48'(-p_ynx_s2) : 48'(p_ynx_s2);
			cc_s3   <= p_ynz_s2[47] ? 48'(-p_ynz_s2) : 48'(p_ynz_s2);
			radt_s3 <= 62'(nsum_w) << 28;

			side_s4 <= side4_w;
			ca_s4   <= ca_s3;
			cb_s4   <= cbm_w[47:0];
			cc_s4   <= cc_s3;
			cd_s4   <= cdm_w[47:0];
			p_s4    <= msb48(or_w);
			radt_s4 <= radt_s3;

			side_s5 <= side5_w;
			ca_s5   <= norm30(ca_s4, p_s4);
			cb_s5   <= norm30(cb_s4, p_s4);
			cc_s5   <= norm30(cc_s4, p_s4);
			radt_s5 <= radt_s4;

			side_s6 <= side_s5;
			qa_s6   <= ca_s5 * ca_s5;
			qb_s6   <= cb_s5 * cb_s5;
			qc_s6   <= cc_s5 * cc_s5;
			radt_s6 <= radt_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sq[0]  <= side_s6;
			sqt[0].rem  <= radt_s6;
			sqt[0].root <= '0;
			sqr[0].rem  <= 62'(qa_s6) + 62'(qb_s6) + 62'(qc_s6);
			sqr[0].root <= '0;
			for (int k = 0; k < SQ_STEPS; k++) begin
				side_sq[k+1] <= side_sq[k];
				sqt[k+1]     <= sq_step(sqt[k], k);
				sqr[k+1]     <= sq_step(sqr[k], k);
			end
		end
	end

	always_comb begin
		side_end = side_sq[SQ_STEPS];
		st_y_w   = 31'(side_end.nz_mag);
		st_x_w   = 32'($signed(side_end.nx));
		th_y_w   = 31'(side_end.ny_mag) << 14;
		th_x_w   = $signed({2'b0, sqt[SQ_STEPS].root[29:0]});
		rk_x_w   = side_end.dot_neg ? -$signed({2'b0, side_end.cd})
		                            : $signed({2'b0, side_end.cd});
	end

	fsdr_angle u_strike (
		.clk (clk),
		.en  (en),
		.y   (st_y_w),
		.x   (st_x_w),
		.ang (ang_st)
	);

	fsdr_angle u_theta (
		.clk (clk),
		.en  (en),
		.y   (th_y_w),
		.x   (th_x_w),
		.ang (ang_th)
	);

	fsdr_angle u_rake (
		.clk (clk),
		.en  (en),
		.y   (sqr[SQ_STEPS].root[30:0]),
		.x   (rk_x_w),
		.ang (ang_rk)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			fin_an[0] <= side_end.fin;
			for (int k = 1; k < ANG_LAT; k++) begin
				fin_an[k] <= fin_an[k-1];
			end
		end
	end

	always_comb begin
		fin_end  = fin_an[ANG_LAT-1];
		strike_w = 15'(ang_st) - 15'(DEG90);
		theta_w  = (ang_th > DEG90) ? DEG90 : ang_th;
		dip_w    = fin_end.fny_pos ? DEG90 + theta_w : DEG90 - theta_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rup_s62   <= fin_end.rup;
			degen_s62 <= fin_end.degen;
			if (fin_end.degen) begin
				strike_s62 <= '0;
				dip_s62    <= '0;
				rake_s62   <= '0;
			end else begin
				strike_s62 <= strike_w[13:0];
				dip_s62    <= dip_w;
				rake_s62   <= (fin_end.rup && fin_end.rake_ok) ? ang_rk : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_sq      <= '{default: 1'b0};
			vld_an      <= '{default: 1'b0};
			res_vld_s62 <= 1'b0;
		end else if (en) begin
			vld_s1    <= item_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_sq[0] <= vld_s6;
			for (int k = 0; k < SQ_STEPS; k++) begin
				vld_sq[k+1] <= vld_sq[k];
			end
			vld_an[0] <= vld_sq[SQ_STEPS];
			for (int k = 1; k < ANG_LAT; k++) begin
				vld_an[k] <= vld_an[k-1];
			end
			res_vld_s62 <= vld_an[ANG_LAT-1];
		end
	end

	assign result_valid = res_vld_s62;
	assign strike_deg   = $signed(strike_s62);
	assign dip_deg      = dip_s62;
	assign rake_deg     = rake_s62;
	assign ruptured     = rup_s62;
	assign degenerate   = degen_s62;

endmodule

### tb/tb_fault_strike_dip_rake_core.sv
// Self-checking testbench for the fault strike, dip and rake core with a built-in angle predictor.
`timescale 1ns / 1ps

module tb_fault_strike_dip_rake_core import fsdr_pkg::*;;

	typedef struct packed {
		logic signed [13:0] strike;
		logic [13:0]        dip;
		logic [13:0]        rake;
		logic               rup;
		logic               degen;
	} angles_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

	logic clk, arst_n;
	logic item_valid, item_stall;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic signed [31:0] slip_x, slip_y, slip_z;
	logic result_valid, result_stall;
	logic signed [13:0] strike_deg;
	logic [13:0] dip_deg, rake_deg;
	logic ruptured, degenerate;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	angles_t expected_angles[$];
	longint unsigned threshold;
	int send_idle_pct, recv_idle_pct;
	bit hold_request;
	bit hold_seen;
	int errors;
	int idle_cycles;

	fault_strike_dip_rake_core i_dut (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned mag64(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint asr64(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint arctan_q64(longint unsigned y, longint x);
		longint unsigned ux, m;
		longint cx, cy, z, nx;
		ux = mag64(x);
		z = 0;
		if (y == 0 && ux == 0) return 0;
		if (y == 0) return (x > 0) ? 0 : 11520;
		if (ux == 0) return 5760;
		m = (y > ux) ? y : ux;
		while (m >= (64'd1 << 30)) begin
			m >>= 1; y >>= 1; ux >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1; y <<= 1; ux <<= 1;
		end
		cx = longint'(ux);
		cy = longint'(y);
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (cy > 0) begin
				nx = cx + asr64(cy, i);
				cy = cy - asr64(cx, i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = cx - asr64(cy, i);
				cy = cy + asr64(cx, i);
				z -= longint'(ATAN_TAB[i]);
			end
			cx = nx;
		end
		if (x < 0) z = 180 * 65536 - z;
		if (z < 0) z = 0;
		if (z > 180 * 65536) z = 180 * 65536;
		return (z + 512) >>> 10;
	endfunction

	function automatic angles_t fault_angles(logic signed [15:0] fx, logic signed [15:0] fy,
			logic signed [15:0] fz, logic signed [31:0] sx32, logic signed [31:0] sy32,
			logic signed [31:0] sz32);
		angles_t a;
		longint nx, ny, nz, sx, sy, sz, strike, dip, rake, theta, dotp;
		longint unsigned ax, ay, az, ca, cb, cc, cd, m, h;
		bit rup, degen;
		nx = fx; ny = fy; nz = fz; sx = sx32; sy = sy32; sz = sz32;
		strike = 0; dip = 0; rake = 0;
		ax = mag64(sx); ay = mag64(sy); az = mag64(sz);
		if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31) || az >= (64'd1 << 31))
			rup = 1;
		else
			rup = (ax * ax + ay * ay + az * az) > threshold * threshold;
		degen = (nx == 0 && nz == 0);
		if (!degen) begin
			strike = arctan_q64(mag64(nz), nx) - 5760;
			h = int_sqrt(longint'(nx * nx + nz * nz) << 28);
			theta = arctan_q64(mag64(ny) << 14, longint'(h));
			if (theta > 5760) theta = 5760;
			dip = (ny > 0) ? 5760 + theta : 5760 - theta;
			if (rup) begin
				dotp = sx * nz - sz * nx;
				ca = mag64(sy * nx);
				cb = mag64(sx * nx + sz * nz);
				cc = mag64(sy * nz);
				cd = mag64(dotp);
				m = ca;
				if (cb > m) m = cb;
				if (cc > m) m = cc;
				if (cd > m) m = cd;
				if (m != 0) begin
					while (m >= (64'd1 << 30)) begin
						m >>= 1; ca >>= 1; cb >>= 1; cc >>= 1; cd >>= 1;
					end
					while (m < (64'd1 << 29)) begin
						m <<= 1; ca <<= 1; cb <<= 1; cc <<= 1; cd <<= 1;
					end
					rake = arctan_q64(int_sqrt(ca * ca + cb * cb + cc * cc),
						(dotp < 0) ? -longint'(cd) : longint'(cd));
				end
			end
		end
		a.strike = strike[13:0];
		a.dip = dip[13:0];
		a.rake = rake[13:0];
		a.rup = rup;
		a.degen = degen;
		return a;
	endfunction

	task automatic send_point(logic signed [15:0] fx, logic signed [15:0] fy,
			logic signed [15:0] fz, logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		normal_x <= fx; normal_y <= fy; normal_z <= fz;
		slip_x <= sx; slip_y <= sy; slip_z <= sz;
		expected_angles.push_back(fault_angles(fx, fy, fz, sx, sy, sz));
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_empty();
		item_valid <= 1'b0;
		while (expected_angles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [30:0] value);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_THRESHOLD; pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold = 64'(value);
	endtask

	function automatic logic [31:0] rand_slip();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			2: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
			default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	function automatic logic [15:0] rand_normal();
		case ($urandom_range(5))
			0: return 16'sd0;
			1: return 16'($signed($urandom_range(0, 32)) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_point(16'sh4000, 16'sh0000, 16'sh0000, 32'sh00010000, 0, 0);
		send_point(16'sh0000, 16'sh4000, 16'sh0000, 32'sh00010000, 0, 0);
		send_point(16'sh0000, -16'sh4000, 16'sh0000, 0, 0, 0);
		send_point(16'sh0000, 16'sh0000, 16'sh0000, 32'sh7fffffff, 0, 0);
		send_point(-16'sh8000, -16'sh8000, -16'sh8000, 32'sh80000000, 32'sh80000000,
			32'sh80000000);
		send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff);
		send_point(-16'sh4000, 16'sh0000, 16'sh0000, 0, 32'sh00010000, 0);
		send_point(16'sh0000, 16'sh0000, 16'sh4000, 0, 0, 32'sh00010000);
		send_point(16'sh0000, 16'sh0000, -16'sh4000, 32'sh00010000, 0, 0);
		send_point(16'sh2d41, -16'sh2d41, 16'sh0000, 0, 32'sh00010000, 32'sh00010000);
		send_point(16'sh0001, 16'sh0000, 16'sh0001, 1, 1, 1);
		send_point(16'sh4000, 16'sh0000, 16'sh0000, 0, 32'sh00010000, 0);
		send_point(16'sh4000, 16'sh0001, 16'sh4000, -32'sh00010000, 0, 32'sh00010000);
		send_point(16'sh4000, 16'sh0000, 16'sh0000, 0, 0, 0);
		send_point(-16'sh0001, 16'sh7fff, 16'sh0000, -1, -1, -1);
	endtask

	task automatic test_threshold_edges();
		wait_empty();
		write_threshold(31'h10000);
		send_point(16'sh4000, 16'sh1000, 16'sh0000, 32'sh00010000, 0, 0);
		send_point(16'sh4000, 16'sh1000, 16'sh0000, 32'sh00010001, 0, 0);
		send_point(16'sh4000, 16'sh1000, 16'sh0000, 0, -32'sh00010000, 0);
		send_point(16'sh4000, 16'sh1000, 16'sh2000, 32'sh0000b505, 32'sh0000b505, 0);
		wait_empty();
		write_threshold(31'h7fffffff);
		send_point(16'sh4000, 16'sh0000, 16'sh1000, 32'sh7fffffff, 0, 0);
		send_point(16'sh4000, 16'sh0000, 16'sh1000, 32'sh80000000, 0, 0);
		send_point(16'sh4000, 16'sh0000, 16'sh1000, 32'sh7fffffff, 32'sh7fffffff, 0);
		wait_empty();
	endtask

	task automatic test_random(int count, int s_idle, int r_idle);
		logic [30:0] thr;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		wait_empty();
		case ($urandom_range(3))
			0: thr = '0;
			1: thr = 31'($urandom_range(0, 1 << 22));
			2: thr = 31'($urandom_range(0, 1 << 28));
			default: thr = 31'($urandom);
		endcase
		write_threshold(thr);
		repeat (count)
			send_point(rand_normal(), rand_normal(), rand_normal(), rand_slip(),
				rand_slip(), rand_slip());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		repeat (120)
			send_point(rand_normal(), rand_normal(), rand_normal(), rand_slip(),
				rand_slip(), rand_slip());
		wait_empty();
		repeat (40)
			send_point(rand_normal(), rand_normal(), rand_normal(), rand_slip(),
				rand_slip(), rand_slip());
	endtask

	always @(posedge clk) begin
		if (hold_request && !hold_seen) begin
			hold_seen <= 1'b1;
			result_stall <= 1'b1;
			repeat (200) @(posedge clk);
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		angles_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result strike %0d dip %0d rake %0d", $time,
					strike_deg, dip_deg, rake_deg);
				errors++;
			end else begin
				want = expected_angles.pop_front();
				if (strike_deg !== want.strike || dip_deg !== want.dip ||
						rake_deg !== want.rake || ruptured !== want.rup ||
						degenerate !== want.degen) begin
					$display("%0t: expected s%0d d%0d r%0d rup%0b deg%0b, got s%0d d%0d r%0d rup%0b deg%0b",
						$time, want.strike, want.dip, want.rake, want.rup, want.degen,
						strike_deg, dip_deg, rake_deg, ruptured, degenerate);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		normal_x = '0; normal_y = '0; normal_z = '0;
		slip_x = '0; slip_y = '0; slip_z = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		threshold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_edges();
		test_random(450, 15, 84);
		test_random(450, 84, 15);
		test_random(300, 0, 0);
		test_backpressure();
		wait_empty();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
